// File: src/soft_pwm_event_schedule_macros.svh
// assertion macros shared by the soft pwm schedule builder
`ifndef SOFT_PWM_EVENT_SCHEDULE_MACROS_SVH
`define SOFT_PWM_EVENT_SCHEDULE_MACROS_SVH

// same-cycle implication, checked outside reset
`define SPES_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("spes check failed");

// next-cycle implication, checked outside reset
`define SPES_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("spes check failed");

`endif

// File: src/spes_pkg.sv
// types, constants and helpers of the soft pwm schedule builder
`timescale 1ns / 1ps

package spes_pkg;

  localparam int CHANNELS_DEF = 8;
  localparam int STEPS_DEF    = 256;
  localparam logic [7:0] TICKS_RESET = 8'd115;

  typedef struct packed {
    logic [7:0] duty_0;
    logic [7:0] duty_1;
    logic [7:0] duty_2;
    logic [7:0] duty_3;
    logic [7:0] duty_4;
    logic [7:0] duty_5;
    logic [7:0] duty_6;
    logic [7:0] duty_7;
  } duty_set_t;

  typedef struct packed {
    logic [3:0]  entry_index;
    logic [15:0] delta_ticks;
    logic [7:0]  port_mask;
    logic        last_entry;
  } sched_entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CALC,
    ST_EMIT
  } state_t;

  // control from the sequencer to the level scan
  typedef struct packed {
    logic clear;
    logic step;
  } scan_ctl_t;

  // running result of the level scan
  typedef struct packed {
    logic       found;
    logic [7:0] level;
    logic [7:0] mask;
  } scan_stat_t;

endpackage

// File: src/spes_level_scan.sv
// level scan: finds the smallest level above a floor and the channels at it
`timescale 1ns / 1ps

module spes_level_scan import spes_pkg::*; #(
  parameter int CHANNELS = CHANNELS_DEF,
  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
  input  logic            clk,
  input  logic            rst,
  input  scan_ctl_t       ctl,
  input  logic [CH_W-1:0] ch,
  input  logic [7:0]      duty,
  input  logic [7:0]      floor_level,
  output scan_stat_t      stat
);

  logic       found;
  logic [7:0] level;
  logic [7:0] mask;
  logic [7:0] ch_bit;
  logic       above;
  logic       take;
  logic       join_level;

  assign ch_bit     = 8'(1) << ch;
  assign above      = duty > floor_level;
  assign take       = above && (!found || (duty < level));
  assign join_level = above && found && (duty == level);

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (ctl.clear) begin
      found <= 1'b0;
    end else if (ctl.step && take) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      mask <= '0;
    end else if (ctl.step && take) begin
      level <= duty;
      mask  <= ch_bit;
    end else if (ctl.step && join_level) begin
      mask <= mask | ch_bit;
    end
  end

  assign stat = '{found: found, level: level, mask: mask};

endmodule

// File: src/soft_pwm_event_schedule.sv
// top level of the sorted-compare soft pwm schedule builder
`timescale 1ns / 1ps
`include "soft_pwm_event_schedule_macros.svh"

// Builds a sorted compare schedule for a soft pwm from CHANNELS duty levels.
// A transfer on the duty channel hands in one set of levels; the block then
// emits one schedule entry per transfer on the sched channel: entry 0 holds
// the set mask of every nonzero channel and ticks_per_step times the smallest
// level, each further entry holds an AND clear mask for one distinct level and
// the ticks to the next level (or to the period end on the last entry, which
// carries last_entry). Channels with equal levels share one entry. If every
// channel is off, two entries come out, each with half a period of ticks.
// Datapath: one scan unit walks the captured levels one channel per cycle to
// find the next distinct level, then one multiplier forms the delta and the
// entry moves to the output register, which the sched side can stall.
// The second entry of an all-off item needs no scan. duty_stall stays high
// from acceptance until the last entry is in the output register, so the
// next item may enter while that entry still waits to be taken. ticks_per_step
// is written through cfg_valid/cfg_data, always ready, and must only change
// while no item is in flight.

module soft_pwm_event_schedule import spes_pkg::*; #(
  parameter int CHANNELS = CHANNELS_DEF,
  parameter int STEPS    = STEPS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  // duty level input
  input  logic         duty_valid,
  output logic         duty_stall,
  input  duty_set_t    duty_set,
  // schedule entry output
  output logic         sched_valid,
  input  logic         sched_stall,
  output sched_entry_t sched_entry,
  // ticks_per_step register write
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [7:0]   cfg_data
);

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [7:0] MAX_LEVEL = 8'(STEPS - 1);
  localparam logic [8:0] STEPS_V   = 9'(STEPS);
  // clear mask of the all-off schedule: top channel bit cleared
  localparam logic [7:0] OFF_CLEAR = ~(8'(1) << (CHANNELS - 1));

  state_t state;
  state_t state_next;

  // configuration
  logic [7:0] ticks;

  // captured levels and sequencer registers
  logic [7:0]      duty [CHANNELS];
  logic [7:0]      set_mask;
  logic [CH_W-1:0] ch;
  logic [3:0]      idx;
  logic [7:0]      cur_level;   // level of the entry being built, floor of the scan
  logic [7:0]      cur_mask;    // channels at cur_level
  logic            all_off;     // all channels zero, second entry pending

  // entry waiting for the output register
  sched_entry_t pend;
  sched_entry_t pend_next;

  // shared scan unit
  scan_ctl_t  scan_ctl;
  scan_stat_t scan_stat;

  // sequencer strobes
  logic accept;
  logic load_out;
  logic scan_last;

  // duty capture
  logic [7:0] duty_in [8];
  logic [7:0] in_mask;

  // multiply operands
  logic        is_first;
  logic        half;
  logic [8:0]  opnd;
  logic [16:0] product;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks <= TICKS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      ticks <= cfg_data;
    end
  end

  // unpack and saturate the incoming levels
  always_comb begin
    duty_in[0] = duty_set.duty_0;
    duty_in[1] = duty_set.duty_1;
    duty_in[2] = duty_set.duty_2;
    duty_in[3] = duty_set.duty_3;
    duty_in[4] = duty_set.duty_4;
    duty_in[5] = duty_set.duty_5;
    duty_in[6] = duty_set.duty_6;
    duty_in[7] = duty_set.duty_7;
    for (int c = 0; c < 8; c++) begin
      if (duty_in[c] > MAX_LEVEL) begin
        duty_in[c] = MAX_LEVEL;
      end
    end
    in_mask = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      in_mask[c] = (duty_in[c] != 8'd0);
    end
  end

  assign duty_stall = (state != ST_IDLE);
  assign accept     = duty_valid && !duty_stall;
  assign load_out   = (state == ST_EMIT) && (!sched_valid || !sched_stall);
  assign scan_last  = (ch == CH_W'(CHANNELS - 1));

  // delta operand: a level, a level difference, the rest of the period,
  // or the whole period that gets halved when every channel is off
  always_comb begin
    is_first = (idx == 4'd0);
    half     = 1'b0;
    if (all_off || (is_first && !scan_stat.found)) begin
      opnd = STEPS_V;
      half = 1'b1;
    end else if (is_first) begin
      opnd = {1'b0, scan_stat.level};
    end else if (scan_stat.found) begin
      opnd = {1'b0, scan_stat.level} - {1'b0, cur_level};
    end else begin
      opnd = STEPS_V - {1'b0, cur_level};
    end
    product = 17'(ticks) * 17'(opnd);
  end

  always_comb begin
    pend_next.entry_index = idx;
    pend_next.delta_ticks = half ? product[16:1] : product[15:0];
    if (all_off) begin
      pend_next.port_mask  = OFF_CLEAR;
      pend_next.last_entry = 1'b1;
    end else if (is_first) begin
      pend_next.port_mask  = set_mask;
      pend_next.last_entry = 1'b0;
    end else begin
      pend_next.port_mask  = ~cur_mask;
      pend_next.last_entry = !scan_stat.found;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    scan_ctl.clear = 1'b0;
    scan_ctl.step  = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          scan_ctl.clear = 1'b1;
          state_next     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        scan_ctl.step = 1'b1;
        if (scan_last) begin
          state_next = ST_CALC;
        end
      end
      ST_CALC: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (load_out) begin
          if (pend.last_entry) begin
            state_next = ST_IDLE;
          end else if (all_off) begin
            state_next = ST_CALC;
          end else begin
            scan_ctl.clear = 1'b1;
            state_next     = ST_SCAN;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      all_off <= 1'b0;
    end else if (accept) begin
      all_off <= 1'b0;
    end else if (state == ST_CALC && is_first && !scan_stat.found) begin
      all_off <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int c = 0; c < CHANNELS; c++) begin
        duty[c] <= duty_in[c];
      end
      set_mask  <= in_mask;
      idx       <= 4'd0;
      cur_level <= 8'd0;
    end
    if (scan_ctl.clear) begin
      ch <= '0;
    end else if (scan_ctl.step && !scan_last) begin
      ch <= ch + CH_W'(1);
    end
    if (state == ST_CALC) begin
      pend <= pend_next;
      if (scan_stat.found && !all_off) begin
        cur_level <= scan_stat.level;
        cur_mask  <= scan_stat.mask;
      end
    end
    if (load_out) begin
      idx <= idx + 4'd1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      sched_valid <= 1'b0;
    end else if (load_out) begin
      sched_valid <= 1'b1;
    end else if (!sched_stall) begin
      sched_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      sched_entry <= pend;
    end
  end

  spes_level_scan #(
    .CHANNELS (CHANNELS)
  ) u_scan (
    .clk         (clk),
    .rst         (rst),
    .ctl         (scan_ctl),
    .ch          (ch),
    .duty        (duty[ch]),
    .floor_level (cur_level),
    .stat        (scan_stat)
  );

  // an accepted item always starts with a channel scan
  `SPES_ASSERT_NEXT(a_accept_scans, clk, rst, accept, state == ST_SCAN)
  // the period start entry is never the last one
  `SPES_ASSERT_NOW(a_first_not_last, clk, rst,
      sched_valid && (sched_entry.entry_index == 4'd0), !sched_entry.last_entry)
  // a schedule never runs past one entry per channel plus the set entry
  `SPES_ASSERT_NOW(a_index_bound, clk, rst, state == ST_EMIT,
      pend.entry_index <= 4'(CHANNELS))

endmodule

// File: bench/tb_soft_pwm_event_schedule.sv
// self-checking testbench of the soft pwm compare schedule builder
`timescale 1ns / 1ps

module tb_soft_pwm_event_schedule import spes_pkg::*;;

  // run limits
  localparam int CYCLE_LIMIT   = 400000;
  localparam int HOLD_LEN      = 400;   // long sched-side hold-off
  localparam int DRAIN_TAIL    = 120;   // idle tail before the final check
  localparam int RAND_PER_SET  = 32;
  localparam int PRINT_CAP     = 100;

  // receiver stall patterns
  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_TOGGLE
  } stall_mode_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         duty_valid = 1'b0;
  logic         duty_stall;
  duty_set_t    duty_set = '0;
  logic         sched_valid;
  logic         sched_stall = 1'b0;
  sched_entry_t sched_entry;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [7:0]   cfg_data = 8'd0;

  // bench copy of the ticks_per_step register
  logic [7:0]   ticks_model = TICKS_RESET;

  duty_set_t    duty_pending[$];     // duty sets waiting to be offered
  sched_entry_t sched_expected[$];   // predicted schedule entries, oldest first

  int mismatch_count = 0;
  int cycle_count    = 0;

  // long hold-off requests, raised by the stimulus, served by the receiver
  int hold_requests = 0;
  int hold_served   = 0;

  soft_pwm_event_schedule DUT (
    .clk         (clk),
    .rst         (rst),
    .duty_valid  (duty_valid),
    .duty_stall  (duty_stall),
    .duty_set    (duty_set),
    .sched_valid (sched_valid),
    .sched_stall (sched_stall),
    .sched_entry (sched_entry),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatch_count < PRINT_CAP) begin
      $display("tb: mismatch at cycle %0d: %s got %0d want %0d", cycle_count, what, got, want);
    end
    mismatch_count++;
  endtask

  // builds the expected compare schedule of one duty set
  function automatic void build_schedule(input duty_set_t ds, input logic [7:0] t);
    logic [7:0]   lvl [CHANNELS_DEF];
    logic [7:0]   levels [CHANNELS_DEF];
    logic [7:0]   set_mask;
    logic [7:0]   clr;
    logic [31:0]  delta_w;
    int           n;
    int           b;
    bit           seen;
    sched_entry_t e;
    lvl = '{ds.duty_0, ds.duty_1, ds.duty_2, ds.duty_3,
            ds.duty_4, ds.duty_5, ds.duty_6, ds.duty_7};
    n = 0;
    set_mask = '0;
    // levels are never above STEPS-1 at 256 steps, so no saturation here
    for (int c = 0; c < CHANNELS_DEF; c++) begin
      if (lvl[c] != 8'd0) begin
        set_mask[c] = 1'b1;
        seen = 1'b0;
        for (int a = 0; a < n; a++) begin
          if (levels[a] == lvl[c]) seen = 1'b1;
        end
        if (!seen) begin
          // insertion keeps the distinct levels ascending
          b = n;
          while (b > 0 && levels[b - 1] > lvl[c]) begin
            levels[b] = levels[b - 1];
            b--;
          end
          levels[b] = lvl[c];
          n++;
        end
      end
    end
    if (n == 0) begin
      // every channel off: two half-period entries
      delta_w = 32'(t) * 32'(STEPS_DEF) / 32'd2;
      e.entry_index = 4'd0;
      e.delta_ticks = delta_w[15:0];
      e.port_mask   = 8'h00;
      e.last_entry  = 1'b0;
      sched_expected.push_back(e);
      e.entry_index = 4'd1;
      e.port_mask   = ~(8'd1 << (CHANNELS_DEF - 1));
      e.last_entry  = 1'b1;
      sched_expected.push_back(e);
    end else begin
      delta_w = 32'(t) * 32'(levels[0]);
      e.entry_index = 4'd0;
      e.delta_ticks = delta_w[15:0];
      e.port_mask   = set_mask;
      e.last_entry  = 1'b0;
      sched_expected.push_back(e);
      for (int a = 0; a < n; a++) begin
        clr = '0;
        for (int c = 0; c < CHANNELS_DEF; c++) begin
          if (lvl[c] == levels[a]) clr[c] = 1'b1;
        end
        if (a + 1 < n) delta_w = 32'(t) * (32'(levels[a + 1]) - 32'(levels[a]));
        else           delta_w = 32'(t) * (32'(STEPS_DEF) - 32'(levels[a]));
        e.entry_index = 4'(a + 1);
        e.delta_ticks = delta_w[15:0];
        e.port_mask   = ~clr;
        e.last_entry  = (a + 1 == n);
        sched_expected.push_back(e);
      end
    end
  endfunction

  // random duty set: mixes free levels, shared levels, sparse and extreme sets
  function automatic duty_set_t random_duty_set();
    logic [7:0] lv [CHANNELS_DEF];
    logic [7:0] pool [4];
    int         style;
    style = $urandom_range(0, 3);
    for (int p = 0; p < 4; p++) pool[p] = 8'($urandom_range(1, 255));
    for (int c = 0; c < CHANNELS_DEF; c++) begin
      case (style)
        0: begin
          lv[c] = 8'($urandom);
        end
        1: begin
          // few distinct levels, so equal levels merge
          lv[c] = ($urandom_range(0, 5) == 0) ? 8'd0 : pool[$urandom_range(0, 3)];
        end
        2: begin
          lv[c] = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'd0;
        end
        default: begin
          case ($urandom_range(0, 4))
            0: lv[c] = 8'd0;
            1: lv[c] = 8'd1;
            2: lv[c] = 8'd254;
            3: lv[c] = 8'd255;
            default: lv[c] = 8'($urandom);
          endcase
        end
      endcase
    end
    return {lv[0], lv[1], lv[2], lv[3], lv[4], lv[5], lv[6], lv[7]};
  endfunction

  // ---------------------------------------------------------------------------
  // duty driver: bursts of random length, random gaps in between; a payload
  // offered stays put until its transfer, and valid never looks at stall
  // ---------------------------------------------------------------------------
  int burst_left = 0;
  int gap_left   = 0;
  bit offer;

  always @(posedge clk) begin
    if (rst) begin
      duty_valid <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      offer = duty_valid;
      if (duty_valid && !duty_stall) begin
        // transfer: predict its schedule with the register as it stands
        build_schedule(duty_set, ticks_model);
        offer = 1'b0;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          // mostly short gaps, sometimes none, now and then a long one
          gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40)
                                                 : $urandom_range(0, 4);
        end
      end
      if (!offer) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (duty_pending.size() > 0) begin
          duty_set <= duty_pending.pop_front();
          offer = 1'b1;
          if (burst_left == 0) burst_left = $urandom_range(1, 24);
        end
      end
      duty_valid <= offer;
    end
  end

  // ---------------------------------------------------------------------------
  // sched receiver: stall pattern switches now and then; a long hold-off can
  // be requested, which fills the block up and backs up the duty side
  // ---------------------------------------------------------------------------
  stall_mode_t stall_mode = STALL_NONE;
  int          mode_left  = 0;
  int          hold_left  = 0;
  bit          stall_next;

  always @(posedge clk) begin
    if (rst) begin
      sched_stall <= 1'b0;
    end else begin
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left   = HOLD_LEN;
      end
      if (mode_left == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 3));
        mode_left  = $urandom_range(20, 120);
      end else begin
        mode_left--;
      end
      if (hold_left > 0) begin
        stall_next = 1'b1;
        hold_left--;
      end else begin
        case (stall_mode)
          STALL_NONE:   stall_next = 1'b0;
          STALL_LIGHT:  stall_next = ($urandom_range(0, 3) == 0);
          STALL_HEAVY:  stall_next = ($urandom_range(0, 3) != 0);
          default:      stall_next = ~sched_stall;
        endcase
      end
      sched_stall <= stall_next;
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: every transfer on the sched side against the oldest prediction
  // ---------------------------------------------------------------------------
  sched_entry_t want;

  always @(posedge clk) begin
    if (!rst && sched_valid === 1'b1 && sched_stall === 1'b0) begin
      if (sched_expected.size() == 0) begin
        report_mismatch("unexpected entry, index", sched_entry.entry_index, -1);
      end else begin
        want = sched_expected.pop_front();
        if (sched_entry.entry_index !== want.entry_index)
          report_mismatch("entry_index", sched_entry.entry_index, want.entry_index);
        if (sched_entry.delta_ticks !== want.delta_ticks)
          report_mismatch("delta_ticks", sched_entry.delta_ticks, want.delta_ticks);
        if (sched_entry.port_mask !== want.port_mask)
          report_mismatch("port_mask", sched_entry.port_mask, want.port_mask);
        if (sched_entry.last_entry !== want.last_entry)
          report_mismatch("last_entry", sched_entry.last_entry, want.last_entry);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // wait until every queued set is in and every predicted entry is out;
  // looked at on the falling edge, once the driver has settled
  task automatic wait_drained();
    while (duty_pending.size() != 0 || duty_valid || sched_expected.size() != 0)
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  // register write, only while the block is idle
  task automatic write_ticks(input logic [7:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    ticks_model = value;
    cfg_valid <= 1'b0;
  endtask

  logic [7:0] ticks_plan [5];

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed sets at the reset value of ticks_per_step
    duty_pending.push_back({8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0});
    duty_pending.push_back({8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255});
    duty_pending.push_back({8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1});
    duty_pending.push_back({8'd128, 8'd128, 8'd128, 8'd128, 8'd128, 8'd128, 8'd128, 8'd128});
    duty_pending.push_back({8'd1,   8'd2,   8'd3,   8'd4,   8'd5,   8'd6,   8'd7,   8'd8});
    duty_pending.push_back({8'd8,   8'd7,   8'd6,   8'd5,   8'd4,   8'd3,   8'd2,   8'd1});
    duty_pending.push_back({8'd255, 8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0});
    duty_pending.push_back({8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd1});
    duty_pending.push_back({8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd255});
    duty_pending.push_back({8'd1,   8'd255, 8'd1,   8'd255, 8'd1,   8'd255, 8'd1,   8'd255});
    duty_pending.push_back({8'h55,  8'hAA,  8'h55,  8'hAA,  8'd0,   8'd0,   8'hFF,  8'd0});
    // equal levels scattered across channels merge into shared clear masks
    duty_pending.push_back({8'd7,   8'd3,   8'd7,   8'd0,   8'd3,   8'd200, 8'd200, 8'd7});
    // eight distinct levels, the longest schedule
    duty_pending.push_back({8'd255, 8'd1,   8'd254, 8'd2,   8'd250, 8'd3,   8'd252, 8'd4});
    duty_pending.push_back({8'd128, 8'd0,   8'd128, 8'd0,   8'd0,   8'd0,   8'd0,   8'd0});
    duty_pending.push_back({8'd254, 8'd255, 8'd253, 8'd0,   8'd1,   8'd2,   8'd0,   8'd0});
    duty_pending.push_back({8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd5,   8'd5});
    duty_pending.push_back({8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0});
    wait_drained();

    // random phases across the register range from 1 to 255, both ends included
    ticks_plan = '{8'd1, 8'd255, 8'($urandom_range(1, 255)), 8'hAA,
                   8'($urandom_range(1, 255))};
    for (int ph = 0; ph < 5; ph++) begin
      write_ticks(ticks_plan[ph]);
      // all-off schedule at every setting, so both half-period extremes show up
      duty_pending.push_back('0);
      if (ph == 1) hold_requests++;
      for (int k = 0; k < RAND_PER_SET; k++) begin
        duty_pending.push_back(random_duty_set());
        // midway through the third phase the sender waits for the block to empty out completely
        if (ph == 2 && k == RAND_PER_SET / 2) wait_drained();
      end
      wait_drained();
    end

    repeat (DRAIN_TAIL) @(posedge clk);
    if (sched_expected.size() != 0)
      report_mismatch("entries never produced", 0, sched_expected.size());

    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: soft_pwm_event_schedule.f
+incdir+src
src/spes_pkg.sv
src/spes_level_scan.sv
src/soft_pwm_event_schedule.sv
bench/tb_soft_pwm_event_schedule.sv
